[rtl/core/gww_pkg.sv]
// Shared types, constants and helper functions for the greedy word wrap unit.
package gww_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;

  localparam logic [CHAR_W-1:0] LINE_WIDTH_RST = 8'd80;

  // Register index taken from paddr[2]
  localparam logic REG_LINE_WIDTH = 1'b0;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_of_run;
    logic              failure;
  } out_item_t;

  typedef struct packed {
    logic              wr;
    logic [CHAR_W-1:0] width;
  } cfg_wr_t;

  typedef enum logic [2:0] {
    StIdle,
    StPre1,
    StPre2,
    StRead,
    StSend
  } wrap_state_e;

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic [CHAR_W-1:0] eff_width(input logic [CHAR_W-1:0] w);
    return (w == '0) ? CHAR_W'(1) : w;
  endfunction

endpackage

[rtl/core/gww_stream_if.sv]
// Valid/ready stream channel carrying one item of a chosen payload type.
interface gww_stream_if
  import gww_pkg::*;
#(
  parameter type payload_t = in_item_t
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

[rtl/core/gww_word_mem.sv]
// Word buffer memory: one write port, one read port with registered data.
module gww_word_mem
  import gww_pkg::*;
#(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [CHAR_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [CHAR_W-1:0] rdata_o
);

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/gww_apb_regs.sv]
// APB configuration register file holding the line width.
module gww_apb_regs
  import gww_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CHAR_W-1:0]  line_width_o,
  output cfg_wr_t            cfg_o
);

  logic [CHAR_W-1:0] line_width_q, line_width_d;
  logic              wr_hit;

  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_LINE_WIDTH);

  always_comb begin
    line_width_d = line_width_q;
    if (wr_hit) begin
      line_width_d = pwdata[CHAR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
    end else begin
      line_width_q <= line_width_d;
    end
  end

  assign pready       = 1'b1;
  assign prdata       = (paddr[2] == REG_LINE_WIDTH) ?
                        {{(PDATA_W-CHAR_W){1'b0}}, line_width_q} : '0;
  assign line_width_o = line_width_q;
  assign cfg_o.wr     = wr_hit;
  assign cfg_o.width  = pwdata[CHAR_W-1:0];

endmodule

[rtl/core/greedy_word_wrap_unit.sv]
// Greedy word wrap unit: word buffer sequencer, output register and configuration.
//
// Usage: text bytes arrive one per item on item_i (in_char, end_of_text) and
// the wrapped text leaves one byte per item on result_o (out_char,
// last_of_run, failure). Both channels transfer on valid && ready. The line
// width is set through the APB port at byte address 0 while the unit is idle;
// a write also starts a fresh line.
// Sequencing: an item that emits nothing is only accepted. A blank-line item
// is followed by two newlines from StPre1 and StPre2. A word that ends is
// sent as an optional space or newline from StPre1, then StRead reads the
// first byte and StSend hands out one byte per cycle from the single read
// port of the word memory whenever the output register can take a byte.
// A new item is accepted only after the previous one has handed all its
// bytes to the output register; the last byte may still wait there.
// Reset: clears the sequencer, the word length, the newline count, the
// previous byte and the failure flag, and sets the width to 80. The word
// memory is not cleared; only written entries are read.
// Stall: when result_o.ready is low the output register holds its byte and,
// once it is full, the sequencer waits with the memory read data held.
module greedy_word_wrap_unit
  import gww_pkg::*;
#(
  parameter int unsigned MAX_WORD = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  gww_stream_if.sink         item_i,
  gww_stream_if.source       result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned LEN_W  = $clog2(MAX_WORD + 1);
  localparam int unsigned ADDR_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_WORD);

  wrap_state_e       state_q, state_d;
  logic [LEN_W-1:0]  word_len_q, word_len_d;
  logic [CHAR_W-1:0] width_left_q, width_left_d;
  logic [1:0]        nl_run_q, nl_run_d;
  logic [CHAR_W-1:0] prev_q, prev_d;
  logic              fail_q, fail_d;
  logic [CHAR_W-1:0] pre_char_q, pre_char_d;
  logic              nl2_q, nl2_d;
  logic [LEN_W-1:0]  send_len_q, send_len_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [CHAR_W-1:0] line_width;
  cfg_wr_t           cfg;

  logic              acc, ws, do_emit, at_start, fits, too_long, can_load, load;
  logic [CHAR_W-1:0] c, w;
  logic [CHAR_W:0]   len_x, w_x;
  logic [CHAR_W-1:0] wl_fresh, wl_after_sp;
  logic [1:0]        nl_tmp;
  logic              we, re;
  logic [LEN_W-1:0]  rd_idx, idx_inc;
  logic [CHAR_W-1:0] rdata;

  gww_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .line_width_o (line_width),
    .cfg_o        (cfg)
  );

  gww_word_mem #(
    .DEPTH  (MAX_WORD),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (word_len_q[ADDR_W-1:0]),
    .wdata_i (c),
    .re_i    (re),
    .raddr_i (rd_idx[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  assign item_i.ready = (state_q == StIdle);
  assign acc          = item_i.valid && item_i.ready;
  assign c            = item_i.payload.in_char;
  assign ws           = is_ws(c);
  assign w            = eff_width(line_width);
  assign len_x        = (CHAR_W+1)'(word_len_q);
  assign w_x          = {1'b0, w};
  assign at_start     = (width_left_q == w);
  assign fits         = (len_x + 1'b1) < {1'b0, width_left_q};
  assign too_long     = len_x > w_x;
  assign wl_fresh     = (len_x >= w_x) ? '0 : (w - CHAR_W'(word_len_q));
  assign wl_after_sp  = width_left_q - CHAR_W'(len_x + 1'b1);
  assign do_emit      = (item_i.payload.end_of_text || (ws && (prev_q != CHAR_SPACE)))
                        && (word_len_q != '0);
  assign nl_tmp       = ((c == CHAR_NEWLINE) && (nl_run_q < 2'd2)) ? nl_run_q + 2'd1
                                                                   : nl_run_q;
  assign can_load     = !out_valid_q || result_o.ready;
  assign idx_inc      = idx_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    word_len_d   = word_len_q;
    width_left_d = width_left_q;
    nl_run_d     = nl_run_q;
    prev_d       = prev_q;
    fail_d       = fail_q;
    pre_char_d   = pre_char_q;
    nl2_d        = nl2_q;
    send_len_d   = send_len_q;
    idx_d        = idx_q;
    we           = 1'b0;
    re           = 1'b0;
    rd_idx       = idx_q;
    load         = 1'b0;
    out_d        = out_q;

    unique case (state_q)
      StIdle: begin
        if (acc) begin
          if (do_emit) begin
            send_len_d = word_len_q;
            idx_d      = '0;
            nl2_d      = 1'b0;
            word_len_d = '0;
            priority if (at_start) begin
              state_d      = StRead;
              fail_d       = fail_q | too_long;
              width_left_d = wl_fresh;
            end else if (fits) begin
              state_d      = StPre1;
              pre_char_d   = CHAR_SPACE;
              width_left_d = wl_after_sp;
            end else begin
              state_d      = StPre1;
              pre_char_d   = CHAR_NEWLINE;
              fail_d       = fail_q | too_long;
              width_left_d = wl_fresh;
            end
          end
          if (item_i.payload.end_of_text) begin
            word_len_d   = '0;
            nl_run_d     = '0;
            prev_d       = CHAR_NUL;
            width_left_d = w;
          end else begin
            prev_d = c;
            if (ws) begin
              nl_run_d = nl_tmp;
            end else begin
              nl_run_d = '0;
              if (nl_tmp >= 2'd2) begin
                state_d      = StPre1;
                pre_char_d   = CHAR_NEWLINE;
                nl2_d        = 1'b1;
                width_left_d = w;
              end
              if (word_len_q < MaxLen) begin
                we         = 1'b1;
                word_len_d = word_len_q + 1'b1;
              end else begin
                fail_d = 1'b1;
              end
            end
          end
        end else if (cfg.wr) begin
          width_left_d = eff_width(cfg.width);
        end
      end
      StPre1: begin
        if (can_load) begin
          load    = 1'b1;
          out_d   = '{out_char: pre_char_q, last_of_run: 1'b0, failure: fail_q};
          state_d = nl2_q ? StPre2 : StRead;
        end
      end
      StPre2: begin
        if (can_load) begin
          load    = 1'b1;
          out_d   = '{out_char: CHAR_NEWLINE, last_of_run: 1'b1, failure: fail_q};
          state_d = StIdle;
        end
      end
      StRead: begin
        re      = 1'b1;
        state_d = StSend;
      end
      StSend: begin
        if (can_load) begin
          load  = 1'b1;
          out_d = '{out_char: rdata, last_of_run: (idx_inc == send_len_q),
                    failure: fail_q};
          if (idx_inc == send_len_q) begin
            state_d = StIdle;
          end else begin
            idx_d  = idx_inc;
            re     = 1'b1;
            rd_idx = idx_inc;
          end
        end
      end
      default: state_d = StIdle;
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      word_len_q   <= '0;
      width_left_q <= LINE_WIDTH_RST;
      nl_run_q     <= '0;
      prev_q       <= CHAR_NUL;
      fail_q       <= 1'b0;
      pre_char_q   <= CHAR_NUL;
      nl2_q        <= 1'b0;
      send_len_q   <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      word_len_q   <= word_len_d;
      width_left_q <= width_left_d;
      nl_run_q     <= nl_run_d;
      prev_q       <= prev_d;
      fail_q       <= fail_d;
      pre_char_q   <= pre_char_d;
      nl2_q        <= nl2_d;
      send_len_q   <= send_len_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_len_q <= MaxLen)
    else $error("word length beyond buffer depth");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSend || state_q == StRead) |-> (idx_q < send_len_q))
    else $error("read index past word end");

  a_width_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    width_left_q <= w)
    else $error("width left exceeds line width");

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q |=> fail_q)
    else $error("failure flag dropped");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && item_i.payload.end_of_text) |=> (word_len_q == '0 && nl_run_q == '0))
    else $error("end marker left word state");

endmodule

[bench/wrap_checker.sv]
// Checker for the word wrap unit: predicts wrapped output and compares it with the result channel.
`timescale 1ns / 1ps

module wrap_checker
  import gww_pkg::*;
#(
  parameter int unsigned MAX_WORD = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  logic               item_ready_i,
  input  in_item_t           item_payload_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  out_item_t          res_payload_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  input  logic [PDATA_W-1:0] prdata_i,
  input  logic               pready_i,
  output int unsigned        pending_o,
  output int unsigned        fail_count_o
);

  logic [CHAR_W-1:0] line_width;
  logic [CHAR_W-1:0] word_buf [MAX_WORD];
  int unsigned       word_len;
  logic [CHAR_W-1:0] width_left;
  int unsigned       nl_run;
  logic [CHAR_W-1:0] prev_char;
  logic              fail_flag;
  logic [CHAR_W-1:0] step_chars [$];
  out_item_t         wrapped_q [$];
  int unsigned       mismatches;
  int unsigned       results_seen;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic int unsigned usable_width();
    return (line_width == 8'd0) ? 1 : int'(line_width);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic start_line_with(input int unsigned len, input int unsigned w);
    if (len > w) fail_flag = 1'b1;
    width_left = (len >= w) ? 8'd0 : CHAR_W'(w - len);
  endtask

  task automatic place_word();
    int unsigned len;
    int unsigned w;
    len = word_len;
    w = usable_width();
    if (len == 0) return;
    if (int'(width_left) == w) begin
      start_line_with(len, w);
    end else if (len + 1 < int'(width_left)) begin
      step_chars.push_back(CHAR_SPACE);
      width_left = width_left - CHAR_W'(len + 1);
    end else begin
      step_chars.push_back(CHAR_NEWLINE);
      start_line_with(len, w);
    end
    for (int unsigned i = 0; i < len && i < MAX_WORD; i++) step_chars.push_back(word_buf[i]);
    word_len = 0;
  endtask

  task automatic wrap_step(input in_item_t it);
    logic              blank;
    logic [CHAR_W-1:0] c;
    c = it.in_char;
    step_chars.delete();
    if (it.end_of_text) begin
      place_word();
      word_len = 0;
      nl_run = 0;
      prev_char = CHAR_NUL;
      width_left = CHAR_W'(usable_width());
    end else begin
      blank = is_blank(c);
      if (c == CHAR_NEWLINE && nl_run < 2) nl_run++;
      if (!blank) begin
        if (nl_run >= 2) begin
          step_chars.push_back(CHAR_NEWLINE);
          step_chars.push_back(CHAR_NEWLINE);
          width_left = CHAR_W'(usable_width());
        end
        nl_run = 0;
      end
      if (prev_char != CHAR_SPACE && blank) place_word();
      if (!blank) begin
        if (word_len < MAX_WORD) begin
          word_buf[word_len] = c;
          word_len++;
        end else begin
          fail_flag = 1'b1;
        end
      end
      prev_char = c;
    end
    foreach (step_chars[k]) begin
      wrapped_q.push_back('{out_char: step_chars[k],
                            last_of_run: (k == step_chars.size() - 1),
                            failure: fail_flag});
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (wrapped_q.size() == 0) begin
      report_mismatch($sformatf("result %0d with nothing expected: char %02h",
                                results_seen, got.out_char));
      return;
    end
    want = wrapped_q.pop_front();
    if (got.out_char !== want.out_char)
      report_mismatch($sformatf("result %0d out_char %02h, expected %02h",
                                results_seen, got.out_char, want.out_char));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch($sformatf("result %0d last_of_run %b, expected %b",
                                results_seen, got.last_of_run, want.last_of_run));
    if (got.failure !== want.failure)
      report_mismatch($sformatf("result %0d failure %b, expected %b",
                                results_seen, got.failure, want.failure));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width = LINE_WIDTH_RST;
      word_len = 0;
      width_left = CHAR_W'(usable_width());
      nl_run = 0;
      prev_char = CHAR_NUL;
      fail_flag = 1'b0;
      wrapped_q.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i[PADDR_W-1] == REG_LINE_WIDTH) begin
        if (pwrite_i) begin
          line_width = pwdata_i[CHAR_W-1:0];
          width_left = CHAR_W'(usable_width());
        end else if (prdata_i !== PDATA_W'(line_width)) begin
          report_mismatch($sformatf("line_width read %0h, expected %0h", prdata_i, line_width));
        end
      end
      if (res_valid_i && res_ready_i) check_result(res_payload_i);
      if (item_valid_i && item_ready_i) wrap_step(item_payload_i);
    end
    pending_o <= wrapped_q.size();
    fail_count_o <= mismatches;
  end

endmodule

[bench/tb_top.sv]
// Testbench top for the word wrap unit: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb_top;
  import gww_pkg::*;

  localparam int unsigned          MAX_WORD   = 32;
  localparam logic [PADDR_W-1:0]   WIDTH_ADDR = {REG_LINE_WIDTH, 2'b00};

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int unsigned        pending;
  int unsigned        fail_count;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;

  gww_stream_if #(.payload_t(in_item_t))  item_if ();
  gww_stream_if #(.payload_t(out_item_t)) result_if ();

  greedy_word_wrap_unit #(.MAX_WORD(MAX_WORD)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  wrap_checker #(.MAX_WORD(MAX_WORD)) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_if.valid),
    .item_ready_i   (item_if.ready),
    .item_payload_i (item_if.payload),
    .res_valid_i    (result_if.valid),
    .res_ready_i    (result_if.ready),
    .res_payload_i  (result_if.payload),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(input logic [CHAR_W-1:0] c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.payload <= '{in_char: c, end_of_text: eot};
    do @(posedge clk_i); while (!item_if.ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // hold the sender until every expected byte is out, then let the unit settle
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic program_width(input logic [CHAR_W-1:0] w);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WIDTH_ADDR;
    pwdata <= PDATA_W'(w);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] word_byte();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(255));
    while (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR));
    return c;
  endfunction

  task automatic random_text(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end else if (pick < 12) begin
        send_item(CHAR_W'($urandom_range(255)), 1'b1);
        sent++;
      end else begin
        len = ($urandom_range(19) == 0) ? $urandom_range(40, 33) : $urandom_range(9, 1);
        for (int unsigned i = 0; i < len; i++) send_item(word_byte(), 1'b0);
        sent += len;
        case ($urandom_range(9))
          0, 1, 2, 3, 4: begin
            send_item(CHAR_SPACE, 1'b0);
            sent++;
          end
          5: begin
            send_item(CHAR_SPACE, 1'b0);
            send_item(CHAR_SPACE, 1'b0);
            sent += 2;
          end
          6: begin
            send_item(CHAR_W'($urandom_range(13, 9)), 1'b0);
            sent++;
          end
          7: begin
            send_item(CHAR_NEWLINE, 1'b0);
            sent++;
          end
          8: begin
            send_item(CHAR_NEWLINE, 1'b0);
            send_item(CHAR_SPACE, 1'b0);
            send_item(CHAR_NEWLINE, 1'b0);
            sent += 3;
          end
          default: begin
            repeat (3) send_item(CHAR_NEWLINE, 1'b0);
            sent += 3;
          end
        endcase
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    item_if.valid <= 1'b0;
    item_if.payload <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    send_idle_pct = 29;
    recv_idle_pct = 88;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(8'hFF, 1'b0);
    send_item(CHAR_NUL, 1'b0);
    send_item(CHAR_SPACE, 1'b0);
    send_item(CHAR_SPACE, 1'b0);
    send_text("ab");
    send_item(CHAR_TAB, 1'b0);
    send_text("c");
    send_item(8'h0B, 1'b0);
    send_text("d");
    send_item(8'h0C, 1'b0);
    send_text("e");
    send_item(CHAR_CR, 1'b0);
    send_item(CHAR_NEWLINE, 1'b0);
    send_item(CHAR_NEWLINE, 1'b0);
    send_text("f");
    send_item(8'hA5, 1'b1);

    program_width(8'd0);
    send_text("ab cd");
    send_item(8'h5A, 1'b1);
    program_width(8'd3);
    send_text("abcd x");
    send_item(CHAR_NEWLINE, 1'b0);
    send_item(CHAR_NUL, 1'b1);

    program_width(8'd1);
    random_text(28);
    program_width(CHAR_W'($urandom_range(20, 5)));
    random_text(28);

    send_idle_pct = 88;
    recv_idle_pct = 29;
    program_width(8'd255);
    random_text(28);
    program_width(CHAR_W'($urandom_range(255, 1)));
    random_text(28);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_width(CHAR_W'($urandom_range(12, 3)));
    random_text(28);
    program_width(LINE_WIDTH_RST);
    random_text(28);

    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
